/* hw/rtl/pfdd_pkg.sv */
package pfdd_pkg;

  localparam int FRAC_BITS_DEF = 24;

  // sample_format codes
  localparam logic [1:0] FMT_PCM16 = 2'd0;
  localparam logic [1:0] FMT_PCM24 = 2'd1;
  localparam logic [1:0] FMT_FLOAT = 2'd2;
  localparam logic [1:0] FMT_BAD   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_FRAME_ALIGN   = 2'd2;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [1:0]  chans;
    logic [15:0] align;
  } cfg_t;

  // byte position within the current sample, for positions below eight
  function automatic logic [1:0] pos_mod(input logic [2:0] pos, input logic [1:0] fmt);
    logic [1:0] k;
    k = 2'd0;
    unique case (fmt)
      FMT_PCM16: k = {1'b0, pos[0]};
      FMT_PCM24: begin
        if (pos >= 3'd6) begin
          k = 2'(pos - 3'd6);
        end else if (pos >= 3'd3) begin
          k = 2'(pos - 3'd3);
        end else begin
          k = pos[1:0];
        end
      end
      FMT_FLOAT: k = pos[1:0];
      default:   k = 2'd0;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/pfdd_conv.sv */
module pfdd_conv #(
  parameter int FRAC_BITS = pfdd_pkg::FRAC_BITS_DEF
) (
  input  logic [1:0]             fmt,
  input  logic [23:0]            part,
  input  logic [7:0]             data,
  output logic signed [FRAC_BITS+3:0] value
);

  localparam int VW = FRAC_BITS + 4;
  // a 24-bit mantissa shifted left by up to 12 places
  localparam int MW = 36;
  localparam logic [MW-1:0] LIM = {{(MW-1){1'b0}}, 1'b1} << (FRAC_BITS + 3);

  logic              sgn;
  logic [7:0]        expo;
  logic [22:0]       mant;
  logic [23:0]       mag;
  logic [7:0]        eff_e;
  logic signed [9:0] sh;
  logic signed [9:0] rs;
  logic [MW-1:0]     shifted;
  logic [MW-1:0]     clipped;
  logic signed [VW-1:0] fval;
  logic signed [15:0] s16;
  logic signed [23:0] s24;

  always_comb begin
    sgn   = data[7];
    expo  = {data[6:0], part[23]};
    mant  = part[22:0];
    mag   = {(expo != 8'd0), mant};
    eff_e = (expo == 8'd0) ? 8'd1 : expo;
    sh    = 10'(eff_e) + 10'(FRAC_BITS) - 10'd150;
    rs    = -sh;

    if (sh > 10'sd12) begin
      shifted = (mag != 24'd0) ? LIM : '0;
    end else if (sh >= 10'sd0) begin
      shifted = MW'(mag) << sh[3:0];
    end else if (rs >= 10'sd24) begin
      shifted = '0;
    end else begin
      shifted = MW'(mag >> rs[4:0]);
    end

    // the negative limit wraps to itself when negated
    if (sgn) begin
      clipped = (shifted > LIM) ? LIM : shifted;
      fval    = -$signed(VW'(clipped));
    end else begin
      clipped = (shifted > LIM - MW'(1)) ? LIM - MW'(1) : shifted;
      fval    = $signed(VW'(clipped));
    end

    // infinity saturates, nan gives zero
    if (expo == 8'hFF) begin
      if (mant != 23'd0) begin
        fval = '0;
      end else begin
        fval = sgn ? -$signed(VW'(LIM)) : $signed(VW'(LIM - MW'(1)));
      end
    end

    s16 = $signed({data, part[7:0]});
    s24 = $signed({data, part[15:0]});

    unique case (fmt)
      pfdd_pkg::FMT_PCM16: value = $signed(VW'(s16)) <<< (FRAC_BITS - 15);
      pfdd_pkg::FMT_PCM24: value = $signed(VW'(s24)) <<< (FRAC_BITS - 23);
      pfdd_pkg::FMT_FLOAT: value = fval;
      default:             value = '0;
    endcase
  end

endmodule

/* hw/rtl/pfdd_frame.sv */
module pfdd_frame #(
  parameter int FRAC_BITS = pfdd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfdd_pkg::cfg_t              cfg,
  input  logic                        item_valid,
  input  logic [7:0]                  item_byte,
  input  logic                        item_last,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+3:0] out_mono_sample,
  output logic                        out_bad_format
);

  localparam int VW = FRAC_BITS + 4;
  // up to seven samples can land in one frame across register changes
  localparam int SW = FRAC_BITS + 7;

  logic [15:0]          pos_r, pos_nxt;
  logic [23:0]          part_r, part_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic                 out_valid_r;
  logic signed [VW-1:0] out_mono_r;
  logic                 out_bad_r;

  logic [2:0]           bps;
  logic [3:0]           exp_bytes;
  logic [15:0]          align;
  logic                 bad;
  logic                 in_frame;
  logic [1:0]           k;
  logic                 sample_end;
  logic [23:0]          part_base;
  logic [23:0]          part_ins;
  logic                 frame_done;
  logic signed [VW-1:0] value;
  logic signed [SW-1:0] sum_acc;
  logic signed [SW-1:0] half;
  logic signed [SW-1:0] avg;
  logic                 res_valid;
  logic signed [VW-1:0] res_mono;
  logic                 res_bad;
  logic                 fire;

  pfdd_conv #(.FRAC_BITS(FRAC_BITS)) u_conv (
    .fmt   (cfg.fmt),
    .part  (part_r),
    .data  (item_byte),
    .value (value)
  );

  assign take = !out_valid_r || out_ready;
  assign fire = item_valid && take;

  always_comb begin
    bps        = 3'(cfg.fmt) + 3'd2;
    exp_bytes  = (cfg.chans == 2'd2) ? {bps, 1'b0} : {1'b0, bps};
    align      = (cfg.align == 16'd0) ? 16'(exp_bytes) : cfg.align;
    bad        = (cfg.fmt == pfdd_pkg::FMT_BAD) || (cfg.chans == 2'd0) ||
                 (cfg.chans == 2'd3) || (align < 16'(exp_bytes));
    in_frame   = pos_r < 16'(exp_bytes);
    k          = pfdd_pkg::pos_mod(pos_r[2:0], cfg.fmt);
    sample_end = ({1'b0, k} + 3'd1) == bps;
    part_base  = (k == 2'd0) ? 24'd0 : part_r;
    part_ins   = part_base | (24'(item_byte) << {k, 3'b000});
    frame_done = (17'(pos_r) + 17'd1) >= 17'(align);
    sum_acc    = sum_r + ((in_frame && sample_end) ? SW'(value) : SW'(0));
    // halve rounding toward zero
    half       = $signed(sum_acc + SW'(sum_acc[SW-1])) >>> 1;
    avg        = (cfg.chans == 2'd2) ? half : sum_acc;

    pos_nxt   = pos_r;
    part_nxt  = part_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    res_mono  = '0;
    res_bad   = 1'b0;

    if (bad) begin
      pos_nxt   = '0;
      part_nxt  = '0;
      sum_nxt   = '0;
      res_valid = item_last;
      res_bad   = 1'b1;
    end else begin
      if (in_frame) begin
        if (sample_end) begin
          part_nxt = part_base;
          sum_nxt  = sum_acc;
        end else begin
          part_nxt = part_ins;
        end
      end
      if (frame_done) begin
        res_valid = 1'b1;
        res_mono  = VW'(avg);
        pos_nxt   = '0;
        part_nxt  = '0;
        sum_nxt   = '0;
      end else begin
        pos_nxt = pos_r + 16'd1;
      end
      if (item_last) begin
        pos_nxt  = '0;
        part_nxt = '0;
        sum_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      part_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        pos_r       <= pos_nxt;
        part_r      <= part_nxt;
        sum_r       <= sum_nxt;
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_mono_r <= res_mono;
      out_bad_r  <= res_bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mono_sample = out_mono_r;
  assign out_bad_format  = out_bad_r;

`ifndef NO_ASSERTIONS
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_mono_r == '0)
    else $error("bad format result carries a nonzero sample");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_last |=> pos_r == 16'd0 && part_r == 24'd0 && sum_r == '0)
    else $error("frame state not cleared after end of data");

  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !bad && frame_done |=> out_valid_r && !out_bad_r)
    else $error("completed frame gave no result");
`endif

endmodule

/* hw/rtl/pcm_frame_downmix_decoder.sv */
// pcm frame downmix decoder
// input channel: one byte of the wav data chunk per item (in_data_byte), with
//   in_end_of_data marking the last byte of the chunk
// result channel: one item per completed frame, out_mono_sample is the channel
//   average as signed fixed point with FRAC_BITS fraction bits, saturated at
//   +-8; out_bad_format flags an invalid configuration and then comes only on
//   the end-of-data byte with a zero sample
// configuration channel: cfg_index selects sample_format (0), channel_count (1)
//   or frame_align (2), cfg_data carries the value; always ready, write only
//   while no item is in flight
// result path: the byte that completes a frame passes the input register, then
//   its result is written to the result register, which drives out_valid
// throughput: one byte per cycle; sample assembly, float conversion and the
//   channel sum all settle between the input and result registers
// reset clears the frame position, partial sample and sum and restores the
//   register defaults (pcm 16-bit, one channel, natural alignment)
// when the receiver stalls the result register holds; bytes keep flowing in
//   until the input register is also full, then in_ready drops
module pcm_frame_downmix_decoder #(
  parameter int FRAC_BITS = pfdd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_end_of_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+3:0] out_mono_sample,
  output logic                        out_bad_format,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  pfdd_pkg::cfg_t cfg_r;
  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           in_last_r;
  logic           take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt   <= pfdd_pkg::FMT_PCM16;
      cfg_r.chans <= 2'd1;
      cfg_r.align <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfdd_pkg::REG_SAMPLE_FORMAT: cfg_r.fmt   <= cfg_data[1:0];
        pfdd_pkg::REG_CHANNEL_COUNT: cfg_r.chans <= cfg_data[1:0];
        pfdd_pkg::REG_FRAME_ALIGN:   cfg_r.align <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_end_of_data;
    end
  end

  pfdd_frame #(.FRAC_BITS(FRAC_BITS)) u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .item_valid      (in_valid_r),
    .item_byte       (in_byte_r),
    .item_last       (in_last_r),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mono_sample (out_mono_sample),
    .out_bad_format  (out_bad_format)
  );

endmodule

/* dv/pcm_frame_downmix_decoder_tb.sv */
module pcm_frame_downmix_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = pfdd_pkg::FRAC_BITS_DEF;
  localparam int MONO_W = FRAC + 4;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RAND_BYTES = 1900;

  typedef struct packed {
    logic [MONO_W-1:0] mono;
    logic              bad;
  } mono_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_data_byte;
  logic in_end_of_data;
  logic out_valid;
  logic out_ready;
  logic signed [MONO_W-1:0] out_mono_sample;
  logic out_bad_format;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  pcm_frame_downmix_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_data  (in_end_of_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mono_sample (out_mono_sample),
    .out_bad_format  (out_bad_format),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // decoder model state and registers
  logic [1:0]  cur_fmt = pfdd_pkg::FMT_PCM16;
  logic [1:0]  cur_chans = 2'd1;
  logic [15:0] cur_align = 16'd0;
  int unsigned fr_pos = 0;
  logic [23:0] part_bytes = 24'd0;
  longint      ch_sum = 0;

  mono_res_t pending_mono[$];
  mono_res_t want;
  int mismatch_cnt = 0;
  int byte_cnt = 0;
  int valid_bytes = 0;
  int result_cnt = 0;
  int bad_cnt = 0;
  int cfg_cnt = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  function automatic longint float_to_q24(input logic [31:0] w);
    longint lim;
    longint mag;
    int sh;
    lim = longint'(8) << FRAC;
    if (w[30:23] == 8'hFF) begin
      if (w[22:0] != 0) return 0;
      return w[31] ? -lim : lim - 1;
    end
    if (w[30:23] == 8'h00) begin
      mag = longint'(w[22:0]);
      sh = FRAC - 149;
    end else begin
      mag = longint'({1'b1, w[22:0]});
      sh = int'(w[30:23]) - 150 + FRAC;
    end
    if (sh > 12) mag = (mag != 0) ? lim : 0;
    else if (sh >= 0) mag = mag << sh;
    else if (-sh >= 40) mag = 0;
    else mag = mag >> (-sh);
    if (w[31]) return (mag > lim) ? -lim : -mag;
    return (mag > lim - 1) ? lim - 1 : mag;
  endfunction

  function automatic void clear_frame();
    fr_pos = 0;
    part_bytes = 24'd0;
    ch_sum = 0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eod,
                                      output bit got, output mono_res_t res);
    int unsigned bps;
    int unsigned need;
    int unsigned align;
    int unsigned k;
    longint v;
    longint avg;
    got = 1'b0;
    res = '0;
    bps = int'(cur_fmt) + 2;
    need = int'(cur_chans) * bps;
    align = (cur_align == 0) ? need : int'(cur_align);
    if (cur_fmt == pfdd_pkg::FMT_BAD || cur_chans == 0 || cur_chans > 2 ||
        align < need) begin
      clear_frame();
      if (eod) begin
        got = 1'b1;
        res.bad = 1'b1;
      end
      return;
    end
    if (fr_pos < need) begin
      k = fr_pos % bps;
      if (k == 0) part_bytes = 24'd0;
      if (k + 1 < bps) begin
        part_bytes = part_bytes | (24'(b) << (8 * k));
      end else begin
        if (bps == 2)
          v = longint'($signed({b, part_bytes[7:0]})) * (longint'(1) << (FRAC - 15));
        else if (bps == 3)
          v = longint'($signed({b, part_bytes[15:0]})) * (longint'(1) << (FRAC - 23));
        else v = float_to_q24({b, part_bytes});
        ch_sum += v;
      end
    end
    if (fr_pos + 1 >= align) begin
      // integer divide truncates toward zero
      avg = ch_sum / longint'(cur_chans);
      got = 1'b1;
      res.mono = avg[MONO_W-1:0];
      clear_frame();
    end else begin
      fr_pos = (fr_pos + 1) & 32'hFFFF;
    end
    if (eod) clear_frame();
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // result checker, samples at the falling edge where everything is settled
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_mono.size() == 0) begin
        report_mismatch($sformatf("unexpected item mono=%0d bad=%0b",
                                  out_mono_sample, out_bad_format));
      end else begin
        want = pending_mono.pop_front();
        result_cnt++;
        if (want.bad) bad_cnt++;
        if (out_mono_sample !== want.mono)
          report_mismatch($sformatf("mono_sample got %0d want %0d",
                                    out_mono_sample, $signed(want.mono)));
        if (out_bad_format !== want.bad)
          report_mismatch($sformatf("bad_format got %0b want %0b", out_bad_format, want.bad));
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int stall;
    bit took;
    int n;
    out_ready = 1'b0;
    n = 0;
    @(posedge clk);
    forever begin
      if (n % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
      n++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    bit took;
    bit got;
    mono_res_t res;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_data <= eod;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    decode_byte(b, eod, got, res);
    if (got) pending_mono = {pending_mono, res};
    byte_cnt++;
  endtask

  task automatic send_word(input logic [31:0] w, input int nbytes, input logic eod);
    for (int i = 0; i < nbytes; i++) send_byte(w[8*i +: 8], eod && (i == nbytes - 1));
  endtask

  // wait for all frames to come out, then cover the two-stage pipeline
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_mono.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    case (idx)
      pfdd_pkg::REG_SAMPLE_FORMAT: cur_fmt = data[1:0];
      pfdd_pkg::REG_CHANNEL_COUNT: cur_chans = data[1:0];
      pfdd_pkg::REG_FRAME_ALIGN:   cur_align = data;
      default: ;
    endcase
    cfg_cnt++;
    @(posedge clk);
  endtask

  task automatic set_format(input logic [1:0] fmt, input logic [1:0] nch,
                            input logic [15:0] al);
    logic [13:0] junk;
    // upper data bits of the narrow registers are don't-care
    junk = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'd0;
    write_reg(pfdd_pkg::REG_SAMPLE_FORMAT, {junk, fmt});
    write_reg(pfdd_pkg::REG_CHANNEL_COUNT, {junk, nch});
    write_reg(pfdd_pkg::REG_FRAME_ALIGN, al);
  endtask

  function automatic logic [31:0] pick_sample(input logic [1:0] fmt);
    logic [31:0] w;
    w = $urandom;
    if (fmt == pfdd_pkg::FMT_FLOAT) begin
      case ($urandom_range(0, 5))
        0: ;
        1: w[30:23] = 8'($urandom_range(100, 140));
        2: begin
          w[30:23] = 8'hFF;
          if ($urandom_range(0, 1) == 1) w[22:0] = 23'd0;
        end
        3: w[30:23] = 8'h00;
        4: w[30:23] = 8'($urandom_range(127, 160));
        default: w[30:0] = 31'd0;
      endcase
    end else if ($urandom_range(0, 7) == 0) begin
      w = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      w = w >> (8 * (2 - int'(fmt)));
    end
    return w;
  endfunction

  // reset defaults: pcm16, one channel, natural alignment
  task automatic test_pcm16_mono();
    send_word(32'h8000, 2, 1'b0);
    send_word(32'h7FFF, 2, 1'b0);
    send_word(32'h0001, 2, 1'b1);
    drain_results();
  endtask

  task automatic test_pcm24_stereo();
    set_format(pfdd_pkg::FMT_PCM24, 2'd2, 16'd0);
    send_word(32'h7FFFFF, 3, 1'b0);
    send_word(32'h7FFFFF, 3, 1'b0);
    send_word(32'h800000, 3, 1'b0);
    send_word(32'h000001, 3, 1'b1);
    drain_results();
  endtask

  task automatic test_float_specials();
    set_format(pfdd_pkg::FMT_FLOAT, 2'd1, 16'd0);
    send_word(32'h7F80_0000, 4, 1'b0);  // +inf
    send_word(32'hFF80_0000, 4, 1'b0);  // -inf
    send_word(32'h7FC0_0000, 4, 1'b0);  // nan
    send_word(32'h8000_0000, 4, 1'b0);  // negative zero
    send_word(32'h0000_0001, 4, 1'b0);  // denormal
    send_word(32'h4F00_0000, 4, 1'b0);  // far above +8
    send_word(32'hC100_0000, 4, 1'b0);  // exactly -8
    send_word(32'hB3C0_0000, 4, 1'b1);  // truncates toward zero
    drain_results();
    // odd negative sum, halving must round toward zero
    set_format(pfdd_pkg::FMT_FLOAT, 2'd2, 16'd0);
    send_word(32'hB380_0000, 4, 1'b0);
    send_word(32'h0000_0000, 4, 1'b1);
    drain_results();
  endtask

  task automatic test_frame_padding();
    set_format(pfdd_pkg::FMT_PCM16, 2'd1, 16'd5);
    send_word(32'h1234, 2, 1'b0);
    send_word(32'hA5_5A_FF, 3, 1'b1);
    drain_results();
    set_format(pfdd_pkg::FMT_PCM16, 2'd1, 16'hFFFF);
    send_word(32'h00C3_7F80, 3, 1'b1);
    drain_results();
  endtask

  task automatic test_bad_config();
    set_format(pfdd_pkg::FMT_PCM16, 2'd0, 16'd0);
    send_word(32'h55AA, 2, 1'b1);
    drain_results();
    set_format(pfdd_pkg::FMT_PCM16, 2'd3, 16'd0);
    send_byte(8'hFF, 1'b1);
    drain_results();
    set_format(pfdd_pkg::FMT_BAD, 2'd1, 16'd0);
    send_byte(8'h00, 1'b1);
    drain_results();
    set_format(pfdd_pkg::FMT_PCM16, 2'd1, 16'd1);
    send_byte(8'h80, 1'b1);
    drain_results();
    // partial frame is dropped at end of data
    set_format(pfdd_pkg::FMT_PCM24, 2'd1, 16'd0);
    send_word(32'h7FFF, 2, 1'b1);
    send_word(32'h400000, 3, 1'b1);
    drain_results();
    write_reg(REG_UNUSED, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_midframe_change();
    set_format(pfdd_pkg::FMT_FLOAT, 2'd2, 16'd0);
    send_word(32'h3F80_0000, 4, 1'b0);
    send_byte(8'h77, 1'b0);
    drain_results();
    // position is already past the new frame size, next byte closes the frame
    set_format(pfdd_pkg::FMT_PCM16, 2'd1, 16'd0);
    send_byte(8'h12, 1'b1);
    drain_results();
  endtask

  task automatic test_random_chunks();
    logic [1:0] fmt;
    logic [1:0] nch;
    logic [15:0] al;
    int unsigned need;
    bit ok;
    int pick;
    int ending;
    logic [31:0] w;
    logic [7:0] chunk[$];
    while (valid_bytes < RAND_BYTES) begin
      fmt = 2'($urandom_range(0, 2));
      nch = 2'($urandom_range(1, 2));
      need = int'(nch) * (int'(fmt) + 2);
      case ($urandom_range(0, 3))
        0: al = 16'd0;
        1: al = 16'(need);
        default: al = 16'(need + $urandom_range(1, 6));
      endcase
      ok = 1'b1;
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        ok = 1'b0;
        case ($urandom_range(0, 3))
          0: fmt = pfdd_pkg::FMT_BAD;
          1: nch = 2'd0;
          2: nch = 2'd3;
          default: al = 16'($urandom_range(1, need - 1));
        endcase
      end else if (pick == 1) begin
        al = 16'($urandom_range(need + 7, 65535));
      end
      in_calm = ($urandom_range(0, 3) == 0);
      set_format(fmt, nch, al);
      if ($urandom_range(0, 15) == 0) write_reg(REG_UNUSED, 16'($urandom));
      chunk.delete();
      if (!ok || pick == 1) begin
        repeat ($urandom_range(1, 8)) chunk = {chunk, 8'($urandom)};
      end else begin
        repeat ($urandom_range(1, 10)) begin
          repeat (nch) begin
            w = pick_sample(fmt);
            for (int i = 0; i < int'(fmt) + 2; i++) chunk = {chunk, w[8*i +: 8]};
          end
          repeat ((al == 0) ? 0 : int'(al) - int'(need)) chunk = {chunk, 8'($urandom)};
        end
      end
      // mostly clean chunks; some cut short, some left open into the next setting
      ending = $urandom_range(0, 9);
      if (ending == 0 && chunk.size() > 1) chunk = chunk[0:$urandom_range(0, chunk.size() - 2)];
      foreach (chunk[i]) send_byte(chunk[i], (ending != 9) && (i == chunk.size() - 1));
      if (ok) valid_bytes += chunk.size();
      drain_results();
    end
    in_calm = 1'b0;
  endtask

  initial begin : watchdog
    #20_000_000;
    $display("pcm_frame_downmix_decoder regression: fail");
    $finish;
  end

  initial begin : main_seq
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'd0;
    in_end_of_data = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = pfdd_pkg::REG_SAMPLE_FORMAT;
    cfg_data = 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pcm16_mono();
    test_pcm24_stereo();
    test_float_specials();
    test_frame_padding();
    test_bad_config();
    test_midframe_change();
    test_random_chunks();
    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d bytes (%0d under valid random settings) over %0d register writes",
             byte_cnt, valid_bytes, cfg_cnt);
    $display("checked %0d result items, %0d of them bad-format flags, %0d mismatches",
             result_cnt, bad_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("pcm_frame_downmix_decoder regression: pass");
    end else begin
      $display("pcm_frame_downmix_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pfdd_pkg.sv
hw/rtl/pfdd_conv.sv
hw/rtl/pfdd_frame.sv
hw/rtl/pcm_frame_downmix_decoder.sv
dv/pcm_frame_downmix_decoder_tb.sv
